[design/att_rsp_pkg.sv]
package att_rsp_pkg;

   // PDU size limit and derived widths
   localparam int MAX_PDU_BYTES = 256;
   localparam int POS_W         = $clog2(MAX_PDU_BYTES + 1);

   // result queue
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   // ATT response opcodes
   localparam logic [7:0] OP_ERROR_RSP      = 8'h01;
   localparam logic [7:0] OP_FIND_INFO_RSP  = 8'h05;
   localparam logic [7:0] OP_READ_TYPE_RSP  = 8'h09;
   localparam logic [7:0] OP_READ_RSP       = 8'h0B;
   localparam logic [7:0] OP_READ_GROUP_RSP = 8'h11;
   localparam logic [7:0] OP_WRITE_RSP      = 8'h13;

   // find-information format codes
   localparam logic [7:0] FMT_UUID16  = 8'h01;
   localparam logic [7:0] FMT_UUID128 = 8'h02;

   localparam logic [7:0] ERR_ATTR_NOT_FOUND = 8'h0A;

   // entry sizes and UUID offsets inside an entry
   localparam logic [7:0] FIND_SIZE_16  = 8'd4;
   localparam logic [7:0] FIND_SIZE_128 = 8'd18;
   localparam logic [4:0] FIND_UUID_AT  = 5'd2;
   localparam logic [4:0] TYPE_UUID_AT  = 5'd5;
   localparam logic [4:0] GROUP_UUID_AT = 5'd4;
   localparam logic [7:0] MAX_UUID_BYTES = 8'd16;
   localparam logic [4:0] MAX_ENTRY_BYTES = 5'd21;

   typedef enum logic [2:0] {
      KIND_ERROR   = 3'd0,
      KIND_DESC    = 3'd1,
      KIND_CHAR    = 3'd2,
      KIND_SERVICE = 3'd3,
      KIND_VALUE   = 3'd4,
      KIND_END     = 3'd5
   } rec_kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_ERROR     = 2'd2,
      ST_UNHANDLED = 2'd3
   } pdu_status_type;

   typedef struct packed {
      rec_kind_type   rec_kind;
      logic [15:0]    handle_first;
      logic [15:0]    handle_second;
      logic [7:0]     failed_request_opcode;
      logic [7:0]     att_error_code;
      logic [7:0]     property_bits;
      logic [4:0]     uuid_length;
      logic [63:0]    uuid_low;
      logic [63:0]    uuid_high;
      logic [7:0]     value_octet;
      pdu_status_type pdu_status;
      logic           last_result;
   } rec_type;

   // what one accepted byte pushes into the result queue
   typedef struct packed {
      logic    entry_vld;
      rec_type entry_rec;
      logic    end_vld;
      rec_type end_rec;
   } push_type;

endpackage

[design/att_rsp_parser.sv]
module att_rsp_parser (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  logic [7:0]            data_byte,
   input  logic                  last_byte,
   output att_rsp_pkg::push_type push
);
   import att_rsp_pkg::*;

   logic [POS_W-1:0] pos_ff,   pos_in;
   logic [7:0]       op_ff,    op_in;
   logic [7:0]       esize_ff, esize_in;
   logic [4:0]       eoff_ff,  eoff_in;
   logic [15:0]      ha_ff,    ha_in;
   logic [15:0]      hb_ff,    hb_in;
   logic [7:0]       aux_ff,   aux_in;
   logic [127:0]     uuid_ff,  uuid_in;
   logic             mal_ff,   mal_in;

   logic [4:0]     start;
   rec_kind_type   ekind;
   logic [4:0]     off_next;
   logic [3:0]     lane;
   logic [7:0]     lo_len;
   pdu_status_type status;

   always_comb begin
      case (op_ff)
         OP_FIND_INFO_RSP: begin start = FIND_UUID_AT;  ekind = KIND_DESC;    end
         OP_READ_TYPE_RSP: begin start = TYPE_UUID_AT;  ekind = KIND_CHAR;    end
         default:          begin start = GROUP_UUID_AT; ekind = KIND_SERVICE; end
      endcase
      lo_len   = {3'b000, start};
      off_next = eoff_ff + 5'd1;
      lane     = 4'(eoff_ff - start);
   end

   always_comb begin
      pos_in   = pos_ff;
      op_in    = op_ff;
      esize_in = esize_ff;
      eoff_in  = eoff_ff;
      ha_in    = ha_ff;
      hb_in    = hb_ff;
      aux_in   = aux_ff;
      uuid_in  = uuid_ff;
      mal_in   = mal_ff;
      push     = '0;
      status   = ST_OK;

      if (accept) begin
         if (pos_ff == POS_W'(MAX_PDU_BYTES)) begin
            mal_in = 1'b1;
         end else begin
            if (pos_ff == '0) begin
               op_in = data_byte;
            end else begin
               case (op_ff)
                  OP_ERROR_RSP: begin
                     if (pos_ff == POS_W'(1)) begin
                        aux_in = data_byte;
                     end else if (pos_ff == POS_W'(2)) begin
                        ha_in = {8'h00, data_byte};
                     end else if (pos_ff == POS_W'(3)) begin
                        ha_in = ha_ff | {data_byte, 8'h00};
                     end else if (pos_ff == POS_W'(4)) begin
                        esize_in                        = data_byte;
                        push.entry_vld                  = 1'b1;
                        push.entry_rec.rec_kind         = KIND_ERROR;
                        push.entry_rec.handle_first     = ha_ff;
                        push.entry_rec.failed_request_opcode = aux_ff;
                        push.entry_rec.att_error_code   = data_byte;
                     end
                  end
                  OP_FIND_INFO_RSP, OP_READ_TYPE_RSP, OP_READ_GROUP_RSP: begin
                     if (pos_ff == POS_W'(1)) begin
                        if (op_ff == OP_FIND_INFO_RSP) begin
                           if (data_byte == FMT_UUID16)
                              esize_in = FIND_SIZE_16;
                           else if (data_byte == FMT_UUID128)
                              esize_in = FIND_SIZE_128;
                           else
                              mal_in = 1'b1;
                        end else begin
                           esize_in = data_byte;
                           if (data_byte < lo_len || data_byte > lo_len + MAX_UUID_BYTES)
                              mal_in = 1'b1;
                        end
                     end else if (!mal_ff) begin
                        if (eoff_ff == 5'd0)
                           ha_in = {ha_ff[15:8], data_byte};
                        else if (eoff_ff == 5'd1)
                           ha_in = {data_byte, ha_ff[7:0]};
                        else if (eoff_ff >= start)
                           uuid_in = uuid_ff | (128'(data_byte) << {lane, 3'b000});
                        else if (op_ff == OP_READ_TYPE_RSP && eoff_ff == 5'd2)
                           aux_in = data_byte;
                        else if (eoff_ff == start - 5'd2)
                           hb_in = {hb_ff[15:8], data_byte};
                        else
                           hb_in = {data_byte, hb_ff[7:0]};
                        eoff_in = off_next;
                        // entry complete: send it and start the next one clean
                        if ({3'b000, off_next} >= esize_ff) begin
                           push.entry_vld               = 1'b1;
                           push.entry_rec.rec_kind      = ekind;
                           push.entry_rec.handle_first  = ha_in;
                           push.entry_rec.handle_second =
                              (ekind == KIND_DESC) ? 16'h0000 : hb_in;
                           push.entry_rec.property_bits =
                              (ekind == KIND_CHAR) ? aux_in : 8'h00;
                           push.entry_rec.uuid_length   = 5'(esize_ff - lo_len);
                           push.entry_rec.uuid_low      = uuid_in[63:0];
                           push.entry_rec.uuid_high     = uuid_in[127:64];
                           eoff_in = '0;
                           ha_in   = '0;
                           hb_in   = '0;
                           aux_in  = '0;
                           uuid_in = '0;
                        end
                     end
                  end
                  OP_READ_RSP: begin
                     push.entry_vld             = 1'b1;
                     push.entry_rec.rec_kind    = KIND_VALUE;
                     push.entry_rec.value_octet = data_byte;
                  end
                  default: ;
               endcase
            end
            pos_in = pos_ff + POS_W'(1);
         end

         if (last_byte) begin
            case (op_in)
               OP_ERROR_RSP:
                  if (mal_in || pos_in < POS_W'(5))
                     status = ST_ERROR;
                  else
                     status = (esize_in == ERR_ATTR_NOT_FOUND) ? ST_NOT_FOUND : ST_ERROR;
               OP_FIND_INFO_RSP, OP_READ_TYPE_RSP, OP_READ_GROUP_RSP:
                  status = (mal_in || pos_in < POS_W'(2)) ? ST_ERROR : ST_OK;
               OP_READ_RSP, OP_WRITE_RSP:
                  status = mal_in ? ST_ERROR : ST_OK;
               default:
                  status = ST_UNHANDLED;
            endcase
            push.end_vld             = 1'b1;
            push.end_rec.rec_kind    = KIND_END;
            push.end_rec.pdu_status  = status;
            push.end_rec.last_result = 1'b1;
            pos_in   = '0;
            op_in    = '0;
            esize_in = '0;
            eoff_in  = '0;
            ha_in    = '0;
            hb_in    = '0;
            aux_in   = '0;
            uuid_in  = '0;
            mal_in   = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         op_ff    <= '0;
         esize_ff <= '0;
         eoff_ff  <= '0;
         ha_ff    <= '0;
         hb_ff    <= '0;
         aux_ff   <= '0;
         uuid_ff  <= '0;
         mal_ff   <= 1'b0;
      end else begin
         pos_ff   <= pos_in;
         op_ff    <= op_in;
         esize_ff <= esize_in;
         eoff_ff  <= eoff_in;
         ha_ff    <= ha_in;
         hb_ff    <= hb_in;
         aux_ff   <= aux_in;
         uuid_ff  <= uuid_in;
         mal_ff   <= mal_in;
      end
   end

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_W'(MAX_PDU_BYTES))
      else $error("byte position past PDU limit");

   a_entry_bound: assert property (@(posedge clock) disable iff (reset)
      eoff_ff < MAX_ENTRY_BYTES)
      else $error("entry offset past longest entry");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      push.end_vld |=> (pos_ff == '0 && !mal_ff && eoff_ff == '0))
      else $error("state not cleared after end of PDU");

   a_mal_no_entry: assert property (@(posedge clock) disable iff (reset)
      (accept && mal_ff && op_ff != OP_ERROR_RSP && op_ff != OP_READ_RSP) |->
         !push.entry_vld)
      else $error("entry record from malformed PDU");

endmodule

[design/att_rsp_queue.sv]
module att_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  att_rsp_pkg::push_type push,
   output logic                  room,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output att_rsp_pkg::rec_type  head
);
   import att_rsp_pkg::*;

   rec_type            q_ff [QDEPTH];
   logic [QPTR_W-1:0]  wr_ff,  wr_in;
   logic [QPTR_W-1:0]  rd_ff,  rd_in;
   logic [QCNT_W-1:0]  cnt_ff, cnt_in;
   logic [QPTR_W-1:0]  end_at;
   logic [1:0]         n_push;
   logic               pop;

   assign pop       = rsp_valid && !rsp_stall;
   assign n_push    = {1'b0, push.entry_vld} + {1'b0, push.end_vld};
   assign end_at    = push.entry_vld ? wr_ff + QPTR_W'(1) : wr_ff;
   assign rsp_valid = cnt_ff != '0;
   // room for the worst case of two records from one byte
   assign room      = cnt_ff <= QCNT_W'(QDEPTH - 2);
   assign head      = q_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff + QPTR_W'(n_push);
      rd_in  = pop ? rd_ff + QPTR_W'(1) : rd_ff;
      cnt_in = cnt_ff + QCNT_W'(n_push) - QCNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QDEPTH; i++) begin
         if (push.entry_vld && wr_ff == QPTR_W'(i))
            q_ff[i] <= push.entry_rec;
         else if (push.end_vld && end_at == QPTR_W'(i))
            q_ff[i] <= push.end_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCNT_W'(QDEPTH))
      else $error("result queue overflow");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      (push.entry_vld || push.end_vld) |-> $past(room) || room)
      else $error("push without room");

   a_pop_only: assert property (@(posedge clock) disable iff (reset)
      (pop && n_push == 2'd0) |=> cnt_ff == $past(cnt_ff) - QCNT_W'(1))
      else $error("queue count lost track on pop");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      QCNT_W'(QPTR_W'(wr_ff - rd_ff)) == cnt_ff || cnt_ff == QCNT_W'(QDEPTH))
      else $error("queue pointers disagree with count");

endmodule

[design/att_response_pdu_parser.sv]
// A record enters the result queue with the req transfer that completes it and is offered on rsp_*
// once at the queue head. One PDU byte is taken per cycle while req_stall is low; one record leaves
//   per cycle while rsp_stall is low, so a byte yielding an entry and the end status takes two transfers.
// A four-entry result queue decouples the sides; req_stall rises when fewer than two slots are free.
// Reset (synchronous, active high) clears the parse state and empties the result queue.
module att_response_pdu_parser (
   input  logic                         clock,
   input  logic                         reset,
   // request channel: PDU bytes, opcode first
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [7:0]                   req_data_byte,
   input  logic                         req_last_byte,
   // response channel: one record per transfer
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [2:0]                   rsp_rec_kind,
   output logic [15:0]                  rsp_handle_first,
   output logic [15:0]                  rsp_handle_second,
   output logic [7:0]                   rsp_failed_request_opcode,
   output logic [7:0]                   rsp_att_error_code,
   output logic [7:0]                   rsp_property_bits,
   output logic [4:0]                   rsp_uuid_length,
   output logic [63:0]                  rsp_uuid_low,
   output logic [63:0]                  rsp_uuid_high,
   output logic [7:0]                   rsp_value_octet,
   output logic [1:0]                   rsp_pdu_status,
   output logic                         rsp_last_result
);
   import att_rsp_pkg::*;

   push_type push;
   rec_type  head;
   logic     room;
   logic     accept;

   // a byte is taken only when the queue can hold both records it may produce
   assign req_stall = !room;
   assign accept    = req_valid && !req_stall;

   // byte-level parse: holds the partial entry, emits entry and end records
   att_rsp_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .last_byte (req_last_byte),
      .push      (push)
   );

   // result queue, head drives the response ports directly
   att_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_rec_kind              = head.rec_kind;
   assign rsp_handle_first          = head.handle_first;
   assign rsp_handle_second         = head.handle_second;
   assign rsp_failed_request_opcode = head.failed_request_opcode;
   assign rsp_att_error_code        = head.att_error_code;
   assign rsp_property_bits         = head.property_bits;
   assign rsp_uuid_length           = head.uuid_length;
   assign rsp_uuid_low              = head.uuid_low;
   assign rsp_uuid_high             = head.uuid_high;
   assign rsp_value_octet           = head.value_octet;
   assign rsp_pdu_status            = head.pdu_status;
   assign rsp_last_result           = head.last_result;

   // end record marks the last transfer of a PDU, and only it
   a_last_is_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_result == (rsp_rec_kind == KIND_END)))
      else $error("last_result out of step with record kind");

   // status is only reported on the end record
   a_status_end_only: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_rec_kind != KIND_END) |-> rsp_pdu_status == ST_OK)
      else $error("status on a non-end record");

   // a final byte always leaves a record offered on rsp_* in the cycle after it is taken
   a_last_pushes_end: assert property (@(posedge clock) disable iff (reset)
      (accept && req_last_byte) |=> rsp_valid)
      else $error("final byte produced no result");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
   import att_rsp_pkg::*;

   localparam int CLK_PERIOD = 4;
   // longest stretch with no transfer on either side before the run is called hung
   localparam int IDLE_LIMIT = 4000;
   // cycles allowed after the last record before the verdict
   localparam int DRAIN_CYCLES = 20;
   // an opcode the parser does not decode
   localparam logic [7:0] OP_STRAY = 8'hFF;

   typedef struct {
      logic [7:0] data;
      logic       last;
   } octet_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_rec_kind;
   logic [15:0] rsp_handle_first;
   logic [15:0] rsp_handle_second;
   logic [7:0]  rsp_failed_request_opcode;
   logic [7:0]  rsp_att_error_code;
   logic [7:0]  rsp_property_bits;
   logic [4:0]  rsp_uuid_length;
   logic [63:0] rsp_uuid_low;
   logic [63:0] rsp_uuid_high;
   logic [7:0]  rsp_value_octet;
   logic [1:0]  rsp_pdu_status;
   logic        rsp_last_result;

   att_response_pdu_parser dut (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_data_byte             (req_data_byte),
      .req_last_byte             (req_last_byte),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_rec_kind              (rsp_rec_kind),
      .rsp_handle_first          (rsp_handle_first),
      .rsp_handle_second         (rsp_handle_second),
      .rsp_failed_request_opcode (rsp_failed_request_opcode),
      .rsp_att_error_code        (rsp_att_error_code),
      .rsp_property_bits         (rsp_property_bits),
      .rsp_uuid_length           (rsp_uuid_length),
      .rsp_uuid_low              (rsp_uuid_low),
      .rsp_uuid_high             (rsp_uuid_high),
      .rsp_value_octet           (rsp_value_octet),
      .rsp_pdu_status            (rsp_pdu_status),
      .rsp_last_result           (rsp_last_result)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Queues shared by stimulus, driver and monitor
   // ---------------------------------------------------------------------
   octet_type  pdu_octets[$];       // bytes waiting to be driven
   rec_type    expected_records[$]; // records the parser owes us, oldest first
   logic [7:0] pdu_buf[$];          // PDU under construction
   int         octets_queued = 0;
   int         mismatches = 0;

   // ---------------------------------------------------------------------
   // Parser model: own copy of the per-PDU state
   // ---------------------------------------------------------------------
   int          byte_count = 0;     // bytes of the current PDU taken so far
   logic [7:0]  pdu_op = 8'h00;
   logic [7:0]  ent_size = 8'h00;   // entry size, or the error code of an error PDU
   int          entry_idx = 0;      // offset inside the current entry
   logic [15:0] hnd_a = 16'h0000;
   logic [15:0] hnd_b = 16'h0000;
   logic [7:0]  aux_octet = 8'h00;  // request opcode or properties byte
   logic [63:0] uuid_acc[2] = '{64'h0, 64'h0};
   bit          pdu_bad = 1'b0;

   task automatic clear_entry();
      entry_idx   = 0;
      hnd_a       = '0;
      hnd_b       = '0;
      aux_octet   = '0;
      uuid_acc[0] = '0;
      uuid_acc[1] = '0;
   endtask

   task automatic clear_parse();
      byte_count = 0;
      pdu_op     = '0;
      ent_size   = '0;
      pdu_bad    = 1'b0;
      clear_entry();
   endtask

   // One byte of a find-info, read-by-type or read-by-group-type entry list.
   task automatic entry_octet(input logic [7:0] b);
      int           start_at;
      int           k;
      rec_kind_type kind;
      rec_type      r;
      if (!pdu_bad) begin
         if (pdu_op == OP_FIND_INFO_RSP) begin
            start_at = int'(FIND_UUID_AT);
            kind     = KIND_DESC;
         end else if (pdu_op == OP_READ_TYPE_RSP) begin
            start_at = int'(TYPE_UUID_AT);
            kind     = KIND_CHAR;
         end else begin
            start_at = int'(GROUP_UUID_AT);
            kind     = KIND_SERVICE;
         end
         if (entry_idx == 0) begin
            hnd_a[7:0] = b;
         end else if (entry_idx == 1) begin
            hnd_a[15:8] = b;
         end else if (entry_idx >= start_at) begin
            // UUID bytes land little-endian across the two 64-bit halves
            k = (entry_idx - start_at) & 15;
            uuid_acc[k / 8][8 * (k % 8) +: 8] = uuid_acc[k / 8][8 * (k % 8) +: 8] | b;
         end else if (pdu_op == OP_READ_TYPE_RSP) begin
            // properties, then the value handle
            if (entry_idx == 2)
               aux_octet = b;
            else if (entry_idx == 3)
               hnd_b[7:0] = b;
            else
               hnd_b[15:8] = b;
         end else begin
            // group end handle
            if (entry_idx == 2)
               hnd_b[7:0] = b;
            else
               hnd_b[15:8] = b;
         end
         entry_idx++;
         if (entry_idx >= int'(ent_size)) begin
            r = '0;
            r.rec_kind      = kind;
            r.handle_first  = hnd_a;
            r.handle_second = (kind == KIND_DESC) ? 16'h0000 : hnd_b;
            r.property_bits = (kind == KIND_CHAR) ? aux_octet : 8'h00;
            r.uuid_length   = 5'(int'(ent_size) - start_at);
            r.uuid_low      = uuid_acc[0];
            r.uuid_high     = uuid_acc[1];
            expected_records.push_back(r);
            clear_entry();
         end
      end
   endtask

   // Work out the records one accepted byte produces.
   task automatic parse_octet(input logic [7:0] b, input logic last);
      int             lo;
      rec_type        r;
      pdu_status_type st;
      if (byte_count >= MAX_PDU_BYTES) begin
         // oversized PDU: byte dropped, PDU marked bad
         pdu_bad = 1'b1;
      end else begin
         if (byte_count == 0) begin
            pdu_op = b;
         end else begin
            case (pdu_op)
               OP_ERROR_RSP: begin
                  case (byte_count)
                     1: aux_octet = b;
                     2: hnd_a = {8'h00, b};
                     3: hnd_a[15:8] = b;
                     4: begin
                        ent_size = b;
                        r = '0;
                        r.rec_kind              = KIND_ERROR;
                        r.handle_first          = hnd_a;
                        r.failed_request_opcode = aux_octet;
                        r.att_error_code        = b;
                        expected_records.push_back(r);
                     end
                     default: ;  // trailing bytes ignored
                  endcase
               end
               OP_FIND_INFO_RSP, OP_READ_TYPE_RSP, OP_READ_GROUP_RSP: begin
                  if (byte_count == 1) begin
                     if (pdu_op == OP_FIND_INFO_RSP) begin
                        if (b == FMT_UUID16)
                           ent_size = FIND_SIZE_16;
                        else if (b == FMT_UUID128)
                           ent_size = FIND_SIZE_128;
                        else
                           pdu_bad = 1'b1;
                     end else begin
                        lo = (pdu_op == OP_READ_TYPE_RSP) ? int'(TYPE_UUID_AT)
                                                          : int'(GROUP_UUID_AT);
                        ent_size = b;
                        if (b < lo || b > lo + MAX_UUID_BYTES)
                           pdu_bad = 1'b1;
                     end
                  end else begin
                     entry_octet(b);
                  end
               end
               OP_READ_RSP: begin
                  r = '0;
                  r.rec_kind    = KIND_VALUE;
                  r.value_octet = b;
                  expected_records.push_back(r);
               end
               default: ;
            endcase
         end
         byte_count++;
      end

      if (last) begin
         case (pdu_op)
            OP_ERROR_RSP: begin
               if (!pdu_bad && byte_count >= 5 && ent_size == ERR_ATTR_NOT_FOUND)
                  st = ST_NOT_FOUND;
               else
                  st = ST_ERROR;
            end
            OP_FIND_INFO_RSP, OP_READ_TYPE_RSP, OP_READ_GROUP_RSP: begin
               if (pdu_bad || byte_count < 2)
                  st = ST_ERROR;
               else
                  st = ST_OK;
            end
            OP_READ_RSP, OP_WRITE_RSP: begin
               if (pdu_bad)
                  st = ST_ERROR;
               else
                  st = ST_OK;
            end
            default: st = ST_UNHANDLED;
         endcase
         r = '0;
         r.rec_kind    = KIND_END;
         r.pdu_status  = st;
         r.last_result = 1'b1;
         expected_records.push_back(r);
         clear_parse();
      end
   endtask

   // ---------------------------------------------------------------------
   // Idle pattern: one window in four has no gaps or stalls at all,
   // otherwise mostly short gaps with the odd long one.
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if ((($time / CLK_PERIOD) % 512) < 128)
         return 0;
      if (r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      if (r < 98)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ---------------------------------------------------------------------
   // Driver: one byte per transfer, payload held while stalled
   // ---------------------------------------------------------------------
   int        gap_left = 0;
   octet_type next_octet;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
         clear_parse();
      end else if (!(req_valid && req_stall)) begin
         // byte taken at this edge: predict its records
         if (req_valid)
            parse_octet(req_data_byte, req_last_byte);
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pdu_octets.size() != 0) begin
            next_octet = pdu_octets.pop_front();
            req_valid     <= 1'b1;
            req_data_byte <= next_octet.data;
            req_last_byte <= next_octet.last;
            gap_left = pick_gap();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: stall pattern and record check
   // ---------------------------------------------------------------------
   int      stall_left = 0;
   rec_type want;

   task automatic check_field(input string name, input logic [63:0] exp_val,
                              input logic [63:0] act_val);
      if (act_val !== exp_val) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp_val, act_val);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_records.size() == 0) begin
               $error("unexpected record transfer, kind %0d", rsp_rec_kind);
               mismatches++;
            end else begin
               want = expected_records.pop_front();
               check_field("rec_kind", 64'(want.rec_kind), 64'(rsp_rec_kind));
               check_field("handle_first", 64'(want.handle_first),
                           64'(rsp_handle_first));
               check_field("handle_second", 64'(want.handle_second),
                           64'(rsp_handle_second));
               check_field("failed_request_opcode", 64'(want.failed_request_opcode),
                           64'(rsp_failed_request_opcode));
               check_field("att_error_code", 64'(want.att_error_code),
                           64'(rsp_att_error_code));
               check_field("property_bits", 64'(want.property_bits),
                           64'(rsp_property_bits));
               check_field("uuid_length", 64'(want.uuid_length), 64'(rsp_uuid_length));
               check_field("uuid_low", want.uuid_low, rsp_uuid_low);
               check_field("uuid_high", want.uuid_high, rsp_uuid_high);
               check_field("value_octet", 64'(want.value_octet), 64'(rsp_value_octet));
               check_field("pdu_status", 64'(want.pdu_status), 64'(rsp_pdu_status));
               check_field("last_result", 64'(want.last_result), 64'(rsp_last_result));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 3) == 0)
               stall_left = pick_gap();
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: no transfer on either side for too long means a hang
   // ---------------------------------------------------------------------
   int idle_cycles = 0;

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------
   // PDU construction
   // ---------------------------------------------------------------------
   function automatic logic [7:0] rand_octet();
      int r;
      r = $urandom_range(0, 7);
      if (r == 0)
         return 8'h00;
      if (r == 1)
         return 8'hFF;
      return 8'($urandom());
   endfunction

   function automatic logic [7:0] stray_opcode();
      logic [7:0] op;
      op = rand_octet();
      while (op == OP_ERROR_RSP || op == OP_FIND_INFO_RSP || op == OP_READ_TYPE_RSP ||
             op == OP_READ_RSP || op == OP_READ_GROUP_RSP || op == OP_WRITE_RSP)
         op = rand_octet();
      return op;
   endfunction

   task automatic put(input logic [7:0] b);
      pdu_buf.push_back(b);
   endtask

   // queue the PDU under construction, flagging its final byte
   task automatic emit_pdu();
      foreach (pdu_buf[i])
         pdu_octets.push_back(octet_type'{pdu_buf[i], i == pdu_buf.size() - 1});
      octets_queued += pdu_buf.size();
      pdu_buf.delete();
   endtask

   // opcode, header byte, whole entries, and optionally a partial one
   task automatic list_pdu(input logic [7:0] op, input logic [7:0] hdr,
                           input int entry_bytes, input int count, input bit ragged);
      put(op);
      put(hdr);
      repeat (count * entry_bytes) put(rand_octet());
      if (ragged && entry_bytes > 1)
         repeat ($urandom_range(1, entry_bytes - 1)) put(rand_octet());
   endtask

   task automatic random_pdu();
      int         sel;
      int         len;
      logic [7:0] hdr;
      sel = $urandom_range(0, 99);
      if (sel < 14) begin
         put(OP_ERROR_RSP);
         repeat (3) put(rand_octet());
         if ($urandom_range(0, 1))
            put(ERR_ATTR_NOT_FOUND);
         else
            put(rand_octet());
         if ($urandom_range(0, 7) == 0)
            repeat ($urandom_range(1, 4)) void'(pdu_buf.pop_back());
         else if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 6)) put(rand_octet());
      end else if (sel < 30) begin
         case ($urandom_range(0, 9))
            0: put(OP_FIND_INFO_RSP);  // format byte missing
            1: begin
               hdr = rand_octet();
               if (hdr == FMT_UUID16 || hdr == FMT_UUID128)
                  hdr = 8'h00;
               list_pdu(OP_FIND_INFO_RSP, hdr, int'(FIND_SIZE_16),
                        $urandom_range(0, 2), 1'b1);
            end
            default: begin
               if ($urandom_range(0, 1))
                  list_pdu(OP_FIND_INFO_RSP, FMT_UUID16, int'(FIND_SIZE_16),
                           $urandom_range(0, 4), 1'($urandom_range(0, 1)));
               else
                  list_pdu(OP_FIND_INFO_RSP, FMT_UUID128, int'(FIND_SIZE_128),
                           $urandom_range(0, 2), 1'($urandom_range(0, 1)));
            end
         endcase
      end else if (sel < 48) begin
         case ($urandom_range(0, 9))
            0: put(OP_READ_TYPE_RSP);  // length byte missing
            1: begin
               // length outside the legal window
               if ($urandom_range(0, 1))
                  len = $urandom_range(0, TYPE_UUID_AT - 1);
               else
                  len = $urandom_range(TYPE_UUID_AT + MAX_UUID_BYTES + 1, 255);
               list_pdu(OP_READ_TYPE_RSP, len[7:0], int'(TYPE_UUID_AT),
                        $urandom_range(0, 2), 1'b1);
            end
            default: begin
               case ($urandom_range(0, 2))
                  0: len = TYPE_UUID_AT + 2;
                  1: len = TYPE_UUID_AT + MAX_UUID_BYTES;
                  default: len = $urandom_range(TYPE_UUID_AT, TYPE_UUID_AT + MAX_UUID_BYTES);
               endcase
               list_pdu(OP_READ_TYPE_RSP, len[7:0], len, $urandom_range(0, 3),
                        1'($urandom_range(0, 1)));
            end
         endcase
      end else if (sel < 64) begin
         case ($urandom_range(0, 9))
            0: put(OP_READ_GROUP_RSP);
            1: begin
               if ($urandom_range(0, 1))
                  len = $urandom_range(0, GROUP_UUID_AT - 1);
               else
                  len = $urandom_range(GROUP_UUID_AT + MAX_UUID_BYTES + 1, 255);
               list_pdu(OP_READ_GROUP_RSP, len[7:0], int'(GROUP_UUID_AT),
                        $urandom_range(0, 2), 1'b1);
            end
            default: begin
               case ($urandom_range(0, 2))
                  0: len = GROUP_UUID_AT + 2;
                  1: len = GROUP_UUID_AT + MAX_UUID_BYTES;
                  default: len = $urandom_range(GROUP_UUID_AT, GROUP_UUID_AT + MAX_UUID_BYTES);
               endcase
               list_pdu(OP_READ_GROUP_RSP, len[7:0], len, $urandom_range(0, 3),
                        1'($urandom_range(0, 1)));
            end
         endcase
      end else if (sel < 80) begin
         put(OP_READ_RSP);
         repeat ($urandom_range(0, 24)) put(rand_octet());
      end else if (sel < 88) begin
         put(OP_WRITE_RSP);
         if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) put(rand_octet());
      end else begin
         put(stray_opcode());
         repeat ($urandom_range(0, 6)) put(rand_octet());
      end
      emit_pdu();
   endtask

   // ---------------------------------------------------------------------
   // Stimulus and end of run
   // ---------------------------------------------------------------------
   initial begin
      // error response, attribute not found
      put(OP_ERROR_RSP); put(8'h08); put(8'h34); put(8'h12); put(ERR_ATTR_NOT_FOUND);
      emit_pdu();
      // error response cut short: no record, error status
      put(OP_ERROR_RSP); put(8'hFF);
      emit_pdu();
      // find-info with an illegal format byte
      put(OP_FIND_INFO_RSP); put(8'h03);
      emit_pdu();
      // read-by-type with its length byte missing
      put(OP_READ_TYPE_RSP);
      emit_pdu();
      // read-by-type entry length one short of the minimum
      put(OP_READ_TYPE_RSP); put(8'(TYPE_UUID_AT - 1)); put(8'h00);
      emit_pdu();
      // group entry length implying a UUID over 16 bytes
      put(OP_READ_GROUP_RSP); put(8'(GROUP_UUID_AT + MAX_UUID_BYTES + 1));
      emit_pdu();
      // unhandled opcode
      put(OP_STRAY); put(8'h00);
      emit_pdu();
      put(OP_WRITE_RSP);
      emit_pdu();
      put(OP_READ_RSP); put(8'hFF); put(8'h00);
      emit_pdu();
      // entry completes on the last byte: entry record, then end record
      put(OP_FIND_INFO_RSP); put(FMT_UUID16); put(8'hFF); put(8'hFF); put(8'h00); put(8'h80);
      emit_pdu();

      while (octets_queued < 300)
         random_pdu();
      // oversized read response: bytes past the limit dropped, error status
      put(OP_READ_RSP);
      repeat ($urandom_range(MAX_PDU_BYTES, MAX_PDU_BYTES + 12)) put(rand_octet());
      emit_pdu();
      while (octets_queued < 600)
         random_pdu();
      // oversized PDU with an unhandled opcode keeps the unhandled status
      put(stray_opcode());
      repeat ($urandom_range(MAX_PDU_BYTES, MAX_PDU_BYTES + 6)) put(rand_octet());
      emit_pdu();
      repeat (4) random_pdu();

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pdu_octets.size() != 0 || req_valid || expected_records.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
